[design/bpr_pkg.sv]
// Shared types and constants for the bilinear plasticity return-map block.
// Used by every module of the block; depends on nothing.
`default_nettype none
package bpr_pkg;

	localparam int FRAC_BITS = 32;
	localparam int DATA_W    = 64;
	localparam int MOD_W     = 63;
	localparam int CFG_IDX_W = 2;

	localparam int DIV_W     = MOD_W + FRAC_BITS;
	localparam int DIV_CNT_W = $clog2(DIV_W);

	localparam logic [127:0] MUL_RND = 128'd1 << (FRAC_BITS - 1);
	localparam logic [63:0]  S64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0]  S64_MIN = 64'h8000_0000_0000_0000;

	localparam logic [CFG_IDX_W-1:0] REG_E = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_Y = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_H = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_K = 2'd3;

	localparam logic [1:0] ACT_TRIAL  = 2'd0;
	localparam logic [1:0] ACT_COMMIT = 2'd1;
	localparam logic [1:0] ACT_REVERT = 2'd2;
	localparam logic [1:0] ACT_CLEAR  = 2'd3;

	typedef logic [4:0] op_t;

	localparam op_t OP_NOP    = 5'd0;
	localparam op_t OP_INCR   = 5'd1;
	localparam op_t OP_PRED   = 5'd2;
	localparam op_t OP_MUL_EI = 5'd3;
	localparam op_t OP_TST    = 5'd4;
	localparam op_t OP_SHIFT  = 5'd5;
	localparam op_t OP_MUL_HP = 5'd6;
	localparam op_t OP_SURF   = 5'd7;
	localparam op_t OP_ABS    = 5'd8;
	localparam op_t OP_YF     = 5'd9;
	localparam op_t OP_SLOPE  = 5'd10;
	localparam op_t OP_DENOM  = 5'd11;
	localparam op_t OP_DIV_DP = 5'd12;
	localparam op_t OP_TP     = 5'd13;
	localparam op_t OP_SDP    = 5'd14;
	localparam op_t OP_MUL_KS = 5'd15;
	localparam op_t OP_TB     = 5'd16;
	localparam op_t OP_MUL_ES = 5'd17;
	localparam op_t OP_TST2   = 5'd18;
	localparam op_t OP_DIV_SD = 5'd19;
	localparam op_t OP_MUL_EQ = 5'd20;
	localparam op_t OP_TT     = 5'd21;
	localparam op_t OP_COMMIT = 5'd22;
	localparam op_t OP_REVERT = 5'd23;
	localparam op_t OP_CLEAR  = 5'd24;

	typedef struct packed {
		logic load;
		logic emit;
		op_t  op;
	} cmd_t;

	typedef struct packed {
		logic incr_zero;
		logic yf_neg;
		logic mul_done;
		logic div_done;
	} sts_t;

endpackage
`default_nettype wire

[design/bpr_mul.sv]
// Multi-cycle saturating fixed-point multiplier: four 32x32 partial products,
// a rounding add and a clip stage. Depends on bpr_pkg.
`default_nettype none
module bpr_mul (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [63:0] a,
	input  wire logic [63:0] b,
	output logic             done,
	output logic [63:0]      res,
	output logic             clip
);

	localparam logic [2:0] M_RND = 3'd4;
	localparam logic [2:0] M_FIN = 3'd5;

	logic         busy_q;
	logic [2:0]   step_q;
	logic         done_q;
	logic [63:0]  ma_q, mb_q;
	logic         neg_q;
	logic [127:0] acc_q;
	logic [63:0]  res_q;
	logic         clip_q;

	logic [31:0]  a_part, b_part;
	logic [63:0]  pp;
	logic [6:0]   sh;
	logic [127:0] pp_sh;
	logic [63:0]  mag_r, limit, mag_s, res_n;
	logic         over, sat;

	always_comb begin
		a_part = step_q[0] ? ma_q[63:32] : ma_q[31:0];
		b_part = step_q[1] ? mb_q[63:32] : mb_q[31:0];
		pp     = 64'(a_part) * 64'(b_part);
		sh     = {({1'b0, step_q[0]} + {1'b0, step_q[1]}), 5'b0};
		pp_sh  = {64'b0, pp} << sh;
		mag_r  = acc_q[bpr_pkg::FRAC_BITS+63:bpr_pkg::FRAC_BITS];
		over   = |acc_q[127:bpr_pkg::FRAC_BITS+64];
		limit  = neg_q ? bpr_pkg::S64_MIN : bpr_pkg::S64_MAX;
		sat    = over || (mag_r > limit);
		mag_s  = sat ? limit : mag_r;
		res_n  = neg_q ? (~mag_s + 64'd1) : mag_s;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				if (step_q == M_FIN) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					step_q <= step_q + 3'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			ma_q  <= a[63] ? (~a + 64'd1) : a;
			mb_q  <= b[63] ? (~b + 64'd1) : b;
			neg_q <= a[63] ^ b[63];
			acc_q <= '0;
		end else if (busy_q) begin
			if (!step_q[2]) begin
				acc_q <= acc_q + pp_sh;
			end else if (step_q == M_RND) begin
				acc_q <= acc_q + bpr_pkg::MUL_RND;
			end else begin
				res_q  <= res_n;
				clip_q <= sat;
			end
		end
	end

	assign done = done_q;
	assign res  = res_q;
	assign clip = clip_q;

endmodule
`default_nettype wire

[design/bpr_div.sv]
// Radix-2 restoring divider for nonnegative fixed-point operands, one quotient
// bit per cycle, round to nearest and clip. Depends on bpr_pkg.
`default_nettype none
module bpr_div (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [63:0] n,
	input  wire logic [63:0] d,
	output logic             done,
	output logic [63:0]      res,
	output logic             clip
);

	localparam logic [1:0] D_IDLE = 2'd0;
	localparam logic [1:0] D_RUN  = 2'd1;
	localparam logic [1:0] D_RND  = 2'd2;
	localparam logic [1:0] D_FIN  = 2'd3;

	logic [1:0]                    st_q;
	logic [bpr_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                          done_q;
	logic [bpr_pkg::DIV_W-1:0]     num_q, quo_q;
	logic [63:0]                   rem_q, den_q, res_q;
	logic                          clip_q;

	logic        n_le0, d_le0, ge, inc, sat;
	logic [63:0] trial;

	always_comb begin
		n_le0 = n[63] || (n == '0);
		d_le0 = d[63] || (d == '0);
		trial = {rem_q[62:0], num_q[bpr_pkg::DIV_W-1]};
		ge    = trial >= den_q;
		inc   = rem_q >= (den_q - rem_q);
		sat   = |quo_q[bpr_pkg::DIV_W-1:63];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= D_IDLE;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (st_q)
				D_IDLE: begin
					if (start) begin
						if (n_le0 || d_le0) begin
							done_q <= 1'b1;
						end else begin
							st_q  <= D_RUN;
							cnt_q <= bpr_pkg::DIV_CNT_W'(bpr_pkg::DIV_W - 1);
						end
					end
				end
				D_RUN: begin
					if (cnt_q == '0) begin
						st_q <= D_RND;
					end else begin
						cnt_q <= cnt_q - bpr_pkg::DIV_CNT_W'(1);
					end
				end
				D_RND: st_q <= D_FIN;
				D_FIN: begin
					st_q   <= D_IDLE;
					done_q <= 1'b1;
				end
				default: st_q <= D_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (st_q)
			D_IDLE: begin
				if (start) begin
					if (n_le0) begin
						res_q  <= '0;
						clip_q <= 1'b0;
					end else if (d_le0) begin
						res_q  <= bpr_pkg::S64_MAX;
						clip_q <= 1'b1;
					end else begin
						num_q <= {n[62:0], {bpr_pkg::FRAC_BITS{1'b0}}};
						quo_q <= '0;
						rem_q <= '0;
						den_q <= d;
					end
				end
			end
			D_RUN: begin
				rem_q <= ge ? (trial - den_q) : trial;
				quo_q <= {quo_q[bpr_pkg::DIV_W-2:0], ge};
				num_q <= num_q << 1;
			end
			D_RND: quo_q <= quo_q + bpr_pkg::DIV_W'(inc);
			D_FIN: begin
				res_q  <= sat ? bpr_pkg::S64_MAX : quo_q[63:0];
				clip_q <= sat;
			end
			default: ;
		endcase
	end

	assign done = done_q;
	assign res  = res_q;
	assign clip = clip_q;

endmodule
`default_nettype wire

[design/bpr_datapath.sv]
// Datapath: configuration and material state registers, a shared saturating
// adder, and the multiplier and divider units. Depends on bpr_pkg, bpr_mul, bpr_div.
`default_nettype none
module bpr_datapath (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire bpr_pkg::cmd_t                 cmd,
	output bpr_pkg::sts_t                      sts,
	input  wire logic                          cfg_we,
	input  wire logic [bpr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [bpr_pkg::MOD_W-1:0]     cfg_data,
	input  wire logic [63:0]                   s_total,
	output logic [63:0]                        out_stress,
	output logic [bpr_pkg::MOD_W-1:0]          out_tangent,
	output logic                               out_yielded,
	output logic                               out_saturated
);

	logic [bpr_pkg::MOD_W-1:0] e_q, y_q, h_q, k_q;
	logic [63:0] cs_q, cst_q, cb_q, cp_q, ct_q;
	logic [63:0] ts_q, tst_q, tb_q, tp_q, tt_q;
	logic        clip_q, yld_q;

	logic [63:0] total_q, incr_q, shift_q, surf_q, yf_q, slope_q, denom_q, sdp_q;
	logic [63:0] stress_q;
	logic [bpr_pkg::MOD_W-1:0] tangent_q;
	logic        yielded_q, saturated_q;

	logic [63:0] add_a, add_b, sum, add_res;
	logic        add_sub, add_en, add_ovf;
	logic [63:0] e64, y64, h64, k64, surf_pos;
	logic        surf_gt0;

	logic        mul_start, mul_done, mul_clip;
	logic [63:0] mul_a, mul_b, mul_res;
	logic        div_start, div_done, div_clip;
	logic [63:0] div_n, div_d, div_res;

	always_comb begin
		e64      = {1'b0, e_q};
		y64      = {1'b0, y_q};
		h64      = {1'b0, h_q};
		k64      = {1'b0, k_q};
		surf_gt0 = !surf_q[63] && (surf_q != '0);
		surf_pos = surf_q[63] ? '0 : surf_q;
	end

	// shared saturating add/subtract
	always_comb begin
		add_en  = 1'b1;
		add_sub = 1'b0;
		add_a   = '0;
		add_b   = '0;
		unique case (cmd.op)
			bpr_pkg::OP_INCR:  begin add_a = total_q; add_b = cs_q; add_sub = 1'b1; end
			bpr_pkg::OP_TST:   begin add_a = cst_q; add_b = mul_res; end
			bpr_pkg::OP_SHIFT: begin add_a = tst_q; add_b = tb_q; add_sub = 1'b1; end
			bpr_pkg::OP_SURF:  begin add_a = y64; add_b = mul_res; end
			bpr_pkg::OP_ABS:   begin add_b = shift_q; add_sub = shift_q[63]; end
			bpr_pkg::OP_YF:    begin add_a = yf_q; add_b = surf_pos; add_sub = 1'b1; end
			bpr_pkg::OP_SLOPE: begin add_a = k64; add_b = surf_gt0 ? h64 : '0; end
			bpr_pkg::OP_DENOM: begin add_a = e64; add_b = slope_q; end
			bpr_pkg::OP_TP:    begin add_a = tp_q; add_b = div_res; end
			bpr_pkg::OP_SDP:   begin add_b = div_res; add_sub = shift_q[63]; end
			bpr_pkg::OP_TB:    begin add_a = tb_q; add_b = mul_res; end
			bpr_pkg::OP_TST2:  begin add_a = tst_q; add_b = mul_res; add_sub = 1'b1; end
			default:           add_en = 1'b0;
		endcase
		sum     = add_sub ? (add_a - add_b) : (add_a + add_b);
		add_ovf = (add_sub ? (add_a[63] != add_b[63]) : (add_a[63] == add_b[63]))
			&& (sum[63] != add_a[63]);
		add_res = add_ovf ? (add_a[63] ? bpr_pkg::S64_MIN : bpr_pkg::S64_MAX) : sum;
	end

	always_comb begin
		mul_start = 1'b1;
		mul_a     = '0;
		mul_b     = '0;
		div_start = 1'b0;
		div_n     = yf_q;
		div_d     = denom_q;
		unique case (cmd.op)
			bpr_pkg::OP_MUL_EI: begin mul_a = e64; mul_b = incr_q; end
			bpr_pkg::OP_MUL_HP: begin mul_a = h64; mul_b = tp_q; end
			bpr_pkg::OP_MUL_KS: begin mul_a = k64; mul_b = sdp_q; end
			bpr_pkg::OP_MUL_ES: begin mul_a = e64; mul_b = sdp_q; end
			bpr_pkg::OP_MUL_EQ: begin mul_a = e64; mul_b = div_res; end
			bpr_pkg::OP_DIV_DP: begin mul_start = 1'b0; div_start = 1'b1; end
			bpr_pkg::OP_DIV_SD: begin
				mul_start = 1'b0;
				div_start = 1'b1;
				div_n     = slope_q;
			end
			default: mul_start = 1'b0;
		endcase
	end

	bpr_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.res    (mul_res),
		.clip   (mul_clip)
	);

	bpr_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.n      (div_n),
		.d      (div_d),
		.done   (div_done),
		.res    (div_res),
		.clip   (div_clip)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			e_q    <= '0;
			y_q    <= '0;
			h_q    <= '0;
			k_q    <= '0;
			cs_q   <= '0;
			cst_q  <= '0;
			cb_q   <= '0;
			cp_q   <= '0;
			ct_q   <= '0;
			ts_q   <= '0;
			tst_q  <= '0;
			tb_q   <= '0;
			tp_q   <= '0;
			tt_q   <= '0;
			clip_q <= 1'b0;
			yld_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					bpr_pkg::REG_E: e_q <= cfg_data;
					bpr_pkg::REG_Y: y_q <= cfg_data;
					bpr_pkg::REG_H: h_q <= cfg_data;
					bpr_pkg::REG_K: k_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.load) begin
				clip_q <= 1'b0;
				yld_q  <= 1'b0;
			end else if ((add_en && add_ovf) || (mul_done && mul_clip)
				|| (div_done && div_clip)) begin
				clip_q <= 1'b1;
			end
			unique case (cmd.op)
				bpr_pkg::OP_INCR: ts_q <= total_q;
				bpr_pkg::OP_PRED: begin
					tt_q <= e64;
					tb_q <= cb_q;
					tp_q <= cp_q;
				end
				bpr_pkg::OP_TST:   tst_q <= add_res;
				bpr_pkg::OP_DENOM: yld_q <= 1'b1;
				bpr_pkg::OP_TP:    tp_q  <= add_res;
				bpr_pkg::OP_TB:    tb_q  <= add_res;
				bpr_pkg::OP_TST2:  tst_q <= add_res;
				bpr_pkg::OP_TT:    tt_q  <= mul_res;
				bpr_pkg::OP_COMMIT: begin
					cs_q  <= ts_q;
					cst_q <= tst_q;
					cb_q  <= tb_q;
					cp_q  <= tp_q;
					ct_q  <= tt_q;
				end
				bpr_pkg::OP_REVERT: begin
					ts_q  <= cs_q;
					tst_q <= cst_q;
					tb_q  <= cb_q;
					tp_q  <= cp_q;
					tt_q  <= ct_q;
				end
				bpr_pkg::OP_CLEAR: begin
					cs_q  <= '0;
					cst_q <= '0;
					cb_q  <= '0;
					cp_q  <= '0;
					ct_q  <= e64;
					ts_q  <= '0;
					tst_q <= '0;
					tb_q  <= '0;
					tp_q  <= '0;
					tt_q  <= e64;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			total_q <= s_total;
		end
		unique case (cmd.op)
			bpr_pkg::OP_INCR:  incr_q  <= add_res;
			bpr_pkg::OP_SHIFT: shift_q <= add_res;
			bpr_pkg::OP_SURF:  surf_q  <= add_res;
			bpr_pkg::OP_ABS:   yf_q    <= add_res;
			bpr_pkg::OP_YF:    yf_q    <= add_res;
			bpr_pkg::OP_SLOPE: slope_q <= add_res;
			bpr_pkg::OP_DENOM: denom_q <= add_res;
			bpr_pkg::OP_SDP:   sdp_q   <= add_res;
			default: ;
		endcase
		if (cmd.emit) begin
			stress_q    <= tst_q;
			tangent_q   <= tt_q[bpr_pkg::MOD_W-1:0];
			yielded_q   <= yld_q;
			saturated_q <= clip_q;
		end
	end

	always_comb begin
		sts.incr_zero = (incr_q == '0);
		sts.yf_neg    = yf_q[63];
		sts.mul_done  = mul_done;
		sts.div_done  = div_done;
	end

	assign out_stress    = stress_q;
	assign out_tangent   = tangent_q;
	assign out_yielded   = yielded_q;
	assign out_saturated = saturated_q;

endmodule
`default_nettype wire

[design/bpr_ctrl.sv]
// Controller: sequences the return-map steps for each action and owns the
// input and output handshakes. Depends on bpr_pkg.
`default_nettype none
module bpr_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          s_tvalid,
	output logic               s_tready,
	input  wire logic [1:0]    action,
	output logic               m_tvalid,
	input  wire logic          m_tready,
	input  wire bpr_pkg::sts_t sts,
	output bpr_pkg::cmd_t      cmd
);

	localparam logic [5:0] S_IDLE   = 6'd0;
	localparam logic [5:0] S_INCR   = 6'd1;
	localparam logic [5:0] S_PRED   = 6'd2;
	localparam logic [5:0] S_M1     = 6'd3;
	localparam logic [5:0] S_M1W    = 6'd4;
	localparam logic [5:0] S_TST    = 6'd5;
	localparam logic [5:0] S_SHIFT  = 6'd6;
	localparam logic [5:0] S_M2     = 6'd7;
	localparam logic [5:0] S_M2W    = 6'd8;
	localparam logic [5:0] S_SURF   = 6'd9;
	localparam logic [5:0] S_ABS    = 6'd10;
	localparam logic [5:0] S_YF     = 6'd11;
	localparam logic [5:0] S_YCHK   = 6'd12;
	localparam logic [5:0] S_SLOPE  = 6'd13;
	localparam logic [5:0] S_DENOM  = 6'd14;
	localparam logic [5:0] S_D1     = 6'd15;
	localparam logic [5:0] S_D1W    = 6'd16;
	localparam logic [5:0] S_TP     = 6'd17;
	localparam logic [5:0] S_SDP    = 6'd18;
	localparam logic [5:0] S_M3     = 6'd19;
	localparam logic [5:0] S_M3W    = 6'd20;
	localparam logic [5:0] S_TB     = 6'd21;
	localparam logic [5:0] S_M4     = 6'd22;
	localparam logic [5:0] S_M4W    = 6'd23;
	localparam logic [5:0] S_TST2   = 6'd24;
	localparam logic [5:0] S_D2     = 6'd25;
	localparam logic [5:0] S_D2W    = 6'd26;
	localparam logic [5:0] S_M5     = 6'd27;
	localparam logic [5:0] S_M5W    = 6'd28;
	localparam logic [5:0] S_TT     = 6'd29;
	localparam logic [5:0] S_COMMIT = 6'd30;
	localparam logic [5:0] S_REVERT = 6'd31;
	localparam logic [5:0] S_CLEAR  = 6'd32;
	localparam logic [5:0] S_FIN    = 6'd33;

	logic [5:0] state_q, state_d;
	logic       ovalid_q;

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = ovalid_q;

	always_comb begin
		state_d  = state_q;
		cmd.load = s_tvalid && s_tready;
		cmd.emit = 1'b0;
		cmd.op   = bpr_pkg::OP_NOP;
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					unique case (action)
						bpr_pkg::ACT_TRIAL:  state_d = S_INCR;
						bpr_pkg::ACT_COMMIT: state_d = S_COMMIT;
						bpr_pkg::ACT_REVERT: state_d = S_REVERT;
						bpr_pkg::ACT_CLEAR:  state_d = S_CLEAR;
						default:             state_d = S_IDLE;
					endcase
				end
			end
			S_INCR: begin cmd.op = bpr_pkg::OP_INCR; state_d = S_PRED; end
			S_PRED: begin
				if (sts.incr_zero) begin
					state_d = S_FIN;
				end else begin
					cmd.op  = bpr_pkg::OP_PRED;
					state_d = S_M1;
				end
			end
			S_M1:    begin cmd.op = bpr_pkg::OP_MUL_EI; state_d = S_M1W; end
			S_M1W:   if (sts.mul_done) state_d = S_TST;
			S_TST:   begin cmd.op = bpr_pkg::OP_TST; state_d = S_SHIFT; end
			S_SHIFT: begin cmd.op = bpr_pkg::OP_SHIFT; state_d = S_M2; end
			S_M2:    begin cmd.op = bpr_pkg::OP_MUL_HP; state_d = S_M2W; end
			S_M2W:   if (sts.mul_done) state_d = S_SURF;
			S_SURF:  begin cmd.op = bpr_pkg::OP_SURF; state_d = S_ABS; end
			S_ABS:   begin cmd.op = bpr_pkg::OP_ABS; state_d = S_YF; end
			S_YF:    begin cmd.op = bpr_pkg::OP_YF; state_d = S_YCHK; end
			S_YCHK:  state_d = sts.yf_neg ? S_FIN : S_SLOPE;
			S_SLOPE: begin cmd.op = bpr_pkg::OP_SLOPE; state_d = S_DENOM; end
			S_DENOM: begin cmd.op = bpr_pkg::OP_DENOM; state_d = S_D1; end
			S_D1:    begin cmd.op = bpr_pkg::OP_DIV_DP; state_d = S_D1W; end
			S_D1W:   if (sts.div_done) state_d = S_TP;
			S_TP:    begin cmd.op = bpr_pkg::OP_TP; state_d = S_SDP; end
			S_SDP:   begin cmd.op = bpr_pkg::OP_SDP; state_d = S_M3; end
			S_M3:    begin cmd.op = bpr_pkg::OP_MUL_KS; state_d = S_M3W; end
			S_M3W:   if (sts.mul_done) state_d = S_TB;
			S_TB:    begin cmd.op = bpr_pkg::OP_TB; state_d = S_M4; end
			S_M4:    begin cmd.op = bpr_pkg::OP_MUL_ES; state_d = S_M4W; end
			S_M4W:   if (sts.mul_done) state_d = S_TST2;
			S_TST2:  begin cmd.op = bpr_pkg::OP_TST2; state_d = S_D2; end
			S_D2:    begin cmd.op = bpr_pkg::OP_DIV_SD; state_d = S_D2W; end
			S_D2W:   if (sts.div_done) state_d = S_M5;
			S_M5:    begin cmd.op = bpr_pkg::OP_MUL_EQ; state_d = S_M5W; end
			S_M5W:   if (sts.mul_done) state_d = S_TT;
			S_TT:    begin cmd.op = bpr_pkg::OP_TT; state_d = S_FIN; end
			S_COMMIT: begin cmd.op = bpr_pkg::OP_COMMIT; state_d = S_FIN; end
			S_REVERT: begin cmd.op = bpr_pkg::OP_REVERT; state_d = S_FIN; end
			S_CLEAR:  begin cmd.op = bpr_pkg::OP_CLEAR; state_d = S_FIN; end
			S_FIN: begin
				// hold until the output slot is free
				if (!ovalid_q || m_tready) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			ovalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit) begin
				ovalid_q <= 1'b1;
			end else if (m_tready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

[design/bilinear_plasticity_return_map.sv]
// Uniaxial bilinear mixed-hardening material point, return-map top level.
// Input beat: s_tuser = action (trial, commit, revert, clear), s_tdata = total strain.
// Output beat: stress, tangent, yielded and saturated flags, one per input beat.
// Moduli and yield stress are set through cfg_we/cfg_index/cfg_data; the user must
// write them only while idle, as the block does not enforce it.
// One beat is processed at a time; s_tready is high only while the controller idles.
// Commit, revert and clear go straight to the output; a trial update with zero
// strain increment ends after the increment check, one that stays elastic uses
// two multiplies, and a plastic update is dominated by the two divisions in the
// radix-2 divider, one quotient bit per cycle over 63+FRAC_BITS bits, plus five
// passes through the multiplier.
// The next beat can be accepted in the cycle after a result is registered.
// A finished result sits in the output register; the next beat is accepted while
// it waits, and that next result is held back until m_tready frees the register.
// Reset clears all strain, stress and hardening state and the configuration,
// so stiffness starts at zero until the elastic modulus is written.
// Depends on bpr_pkg, bpr_ctrl, bpr_datapath.
`default_nettype none
module bilinear_plasticity_return_map (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	input  wire logic [63:0]                   s_tdata,   // total_strain
	input  wire logic [1:0]                    s_tuser,   // action
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	output logic [135:0]                       m_tdata,   // stress, tangent, yielded, saturated
	input  wire logic                          cfg_we,
	input  wire logic [bpr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [bpr_pkg::MOD_W-1:0]     cfg_data
);

	bpr_pkg::cmd_t cmd;
	bpr_pkg::sts_t sts;

	logic [63:0]               stress;
	logic [bpr_pkg::MOD_W-1:0] tangent;
	logic                      yielded, saturated;

	bpr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.action   (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	bpr_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_total       (s_tdata),
		.out_stress    (stress),
		.out_tangent   (tangent),
		.out_yielded   (yielded),
		.out_saturated (saturated)
	);

	assign m_tdata = {7'b0, saturated, yielded, tangent, stress};

endmodule
`default_nettype wire
